// File: hw/rtl/bale_pkg.sv
// shared constants, types and helpers of the bounded array list engine
`default_nettype none
package bale_pkg;

  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int MODE_W = 3;
  localparam int POS_W  = 6;
  localparam int CAP_W  = 7;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT_AT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE_LAST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_AT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [ENTRY_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]       raddr;
  } mem_req_t;

  // zero acts as one, anything above the store depth acts as the depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bale_chan_if.sv
// request and result channel interfaces
`default_nettype none
interface bale_in_if;
  logic                             valid;
  logic                             ready;
  logic [bale_pkg::MODE_W-1:0]      mode;
  logic [bale_pkg::POS_W-1:0]       position;
  logic [bale_pkg::ENTRY_WIDTH-1:0] entry_data;

  modport source (output valid, mode, position, entry_data, input ready);
  modport sink   (input valid, mode, position, entry_data, output ready);
endinterface

interface bale_out_if;
  logic                             valid;
  logic                             ready;
  logic [bale_pkg::STAT_W-1:0]      status;
  logic [bale_pkg::ENTRY_WIDTH-1:0] read_data;
  logic [bale_pkg::CNT_W-1:0]       entry_count;
  logic                             is_full;
  logic                             is_empty;

  modport source (output valid, status, read_data, entry_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, status, read_data, entry_count, is_full, is_empty,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bounded_array_list_engine.sv
// top level: configuration port, list controller and entry store
//
// Keeps an ordered list of up to capacity 32-bit entries in a 64-entry store.
// Requests arrive on in_ch (valid/ready): insert at an index, append, remove at
// an index, remove last, read at an index, clear. Each request gives exactly
// one result on out_ch: status, read data, entry count, full and empty flags.
// One request is in flight at a time. A request that moves entries passes
// through the shift sequencer, one entry moved per cycle through the single
// read port and single write port of the store; an insert writes its new
// entry after the last move. Append, and insert/remove that moves nothing,
// also pass through the sequencer; read goes through a read state; remove
// last, clear and rejected requests go straight to the result state.
// The result sits in an output register; the next request is accepted in the
// cycle after the result is loaded there, even if the receiver stalls.
// A stalled receiver holds the following result in the controller.
// capacity is written over the APB port at byte address 0 and reads back.
// Synchronous reset empties the list and sets capacity to 64; the store
// contents are not cleared, only entries below the count are ever read.
`default_nettype none
module bounded_array_list_engine (
  input  wire                             clk,
  input  wire                             rst_n,
  bale_in_if.sink                         in_ch,
  bale_out_if.source                      out_ch,
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire [bale_pkg::ADDR_W-1:0]      cfg_paddr,
  input  wire [bale_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [bale_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import bale_pkg::*;

  logic [CAP_W-1:0]       capacity_r;
  logic                   cfg_wr;
  mem_req_t               mem_req;
  logic [ENTRY_WIDTH-1:0] mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAPACITY) begin
      cfg_prdata = DATA_W'(capacity_r);
    end
  end

  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .capacity  (capacity_r),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bale_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.entry_count <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != STAT_OK |-> out_ch.read_data == '0)
    else $error("read data nonzero on failed request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second request accepted while one is in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.is_empty == (out_ch.entry_count == '0))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

// File: hw/rtl/bale_mem.sv
// entry store: one write port, one read port with registered read data
`default_nettype none
module bale_mem (
  input  wire                             clk,
  input  bale_pkg::mem_req_t              req,
  output logic [bale_pkg::ENTRY_WIDTH-1:0] rdata
);
  import bale_pkg::*;

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/bale_ctrl.sv
// request decode, shift sequencer and result register
`default_nettype none
module bale_ctrl (
  input  wire                               clk,
  input  wire                               rst_n,
  bale_in_if.sink                           in_ch,
  bale_out_if.source                        out_ch,
  input  wire [bale_pkg::CAP_W-1:0]         capacity,
  output bale_pkg::mem_req_t                mem_req,
  input  wire [bale_pkg::ENTRY_WIDTH-1:0]   mem_rdata
);
  import bale_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       mv_r, mv_nxt;
  logic [IDX_W-1:0]       src_r, src_nxt;
  logic [IDX_W-1:0]       wa_r, wa_nxt;
  logic [IDX_W-1:0]       ins_addr_r, ins_addr_nxt;
  logic [ENTRY_WIDTH-1:0] ins_data_r, ins_data_nxt;
  logic                   pend_r, pend_nxt;
  logic                   down_r, down_nxt;
  logic                   do_wr_r, do_wr_nxt;
  logic [STAT_W-1:0]      res_st_r, res_st_nxt;
  logic [ENTRY_WIDTH-1:0] res_rd_r, res_rd_nxt;

  logic                   ov_r;
  logic [STAT_W-1:0]      ost_r;
  logic [ENTRY_WIDTH-1:0] ord_r;
  logic [CNT_W-1:0]       ocnt_r;
  logic                   ofull_r;
  logic                   oempty_r;

  logic             in_fire;
  logic             out_free;
  logic             move_done;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] pos_ext;
  logic [IDX_W-1:0] pos_idx;
  logic             is_full_now;

  // decoded request
  logic [STAT_W-1:0] d_st;
  logic              d_move;
  logic              d_read;
  logic              d_down;
  logic              d_wr;
  logic [CNT_W-1:0]  d_count;
  logic [CNT_W-1:0]  d_mv;
  logic [IDX_W-1:0]  d_src;
  logic [IDX_W-1:0]  d_waddr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;
  assign move_done   = (mv_r == '0) && !pend_r;
  assign cap         = eff_cap(capacity);
  assign pos_ext     = CNT_W'(in_ch.position);
  assign pos_idx     = IDX_W'(in_ch.position);
  assign is_full_now = (count_r >= cap);

  always_comb begin
    d_st    = STAT_OK;
    d_move  = 1'b0;
    d_read  = 1'b0;
    d_down  = 1'b0;
    d_wr    = 1'b0;
    d_count = count_r;
    d_mv    = '0;
    d_src   = pos_idx;
    d_waddr = pos_idx;
    case (in_ch.mode)
      MODE_INSERT_AT: begin
        if (pos_ext > cap - CNT_W'(1) || pos_ext > count_r) begin
          d_st = STAT_INVALID;
        end else if (is_full_now) begin
          d_st = STAT_FULL;
        end else begin
          d_move  = 1'b1;
          d_down  = 1'b1;
          d_wr    = 1'b1;
          d_src   = count_r[IDX_W-1:0] - IDX_W'(1);
          d_mv    = count_r - pos_ext;
          d_count = count_r + CNT_W'(1);
        end
      end
      MODE_APPEND: begin
        if (is_full_now) begin
          d_st = STAT_FULL;
        end else begin
          d_move  = 1'b1;
          d_wr    = 1'b1;
          d_waddr = count_r[IDX_W-1:0];
          d_count = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE_AT: begin
        if (pos_ext >= count_r) begin
          d_st = STAT_INVALID;
        end else begin
          d_move  = 1'b1;
          d_src   = pos_idx + IDX_W'(1);
          d_mv    = count_r - pos_ext - CNT_W'(1);
          d_count = count_r - CNT_W'(1);
        end
      end
      MODE_REMOVE_LAST: begin
        if (count_r == '0) begin
          d_st = STAT_EMPTY;
        end else begin
          d_count = count_r - CNT_W'(1);
        end
      end
      MODE_READ_AT: begin
        if (pos_ext >= count_r) begin
          d_st = STAT_INVALID;
        end else begin
          d_read = 1'b1;
        end
      end
      MODE_CLEAR: begin
        d_count = '0;
      end
      default: begin
        d_st = STAT_INVALID;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (d_move) begin
            state_nxt = S_MOVE;
          end else if (d_read) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MOVE: begin
        if (move_done) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    mv_nxt       = mv_r;
    src_nxt      = src_r;
    wa_nxt       = wa_r;
    ins_addr_nxt = ins_addr_r;
    ins_data_nxt = ins_data_r;
    pend_nxt     = 1'b0;
    down_nxt     = down_r;
    do_wr_nxt    = do_wr_r;
    res_st_nxt   = res_st_r;
    res_rd_nxt   = res_rd_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = wa_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = src_r;
    unique case (state_r)
      S_IDLE: begin
        mem_req.raddr = pos_idx;
        if (in_fire) begin
          count_nxt    = d_count;
          mv_nxt       = d_mv;
          src_nxt      = d_src;
          down_nxt     = d_down;
          do_wr_nxt    = d_wr;
          ins_addr_nxt = d_waddr;
          ins_data_nxt = in_ch.entry_data;
          res_st_nxt   = d_st;
          res_rd_nxt   = '0;
        end
      end
      S_MOVE: begin
        // read one entry ahead, write it to its neighbor in the following cycle
        if (mv_r != '0) begin
          mv_nxt   = mv_r - CNT_W'(1);
          pend_nxt = 1'b1;
          src_nxt  = down_r ? src_r - IDX_W'(1) : src_r + IDX_W'(1);
          wa_nxt   = down_r ? src_r + IDX_W'(1) : src_r - IDX_W'(1);
        end
        if (pend_r) begin
          mem_req.we = 1'b1;
        end else if (mv_r == '0 && do_wr_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ins_addr_r;
          mem_req.wdata = ins_data_r;
        end
      end
      S_READ: begin
        res_rd_nxt = mem_rdata;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      mv_r    <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mv_r    <= mv_nxt;
      pend_r  <= pend_nxt;
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    wa_r       <= wa_nxt;
    ins_addr_r <= ins_addr_nxt;
    ins_data_r <= ins_data_nxt;
    down_r     <= down_nxt;
    do_wr_r    <= do_wr_nxt;
    res_st_r   <= res_st_nxt;
    res_rd_r   <= res_rd_nxt;
    if (state_r == S_DONE && out_free) begin
      ost_r    <= res_st_r;
      ord_r    <= res_rd_r;
      ocnt_r   <= count_r;
      ofull_r  <= is_full_now;
      oempty_r <= (count_r == '0);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.read_data   = ord_r;
  assign out_ch.entry_count = ocnt_r;
  assign out_ch.is_full     = ofull_r;
  assign out_ch.is_empty    = oempty_r;

endmodule
`default_nettype wire

// File: verif/bounded_array_list_engine_checker.sv
// checker: mirrors the ordered list and compares every result transfer with its prediction
`timescale 1ns / 100ps
module bounded_array_list_engine_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  bale_in_if                            in_mon,
  bale_out_if                           out_mon,
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire                           cfg_pready,
  input  wire [bale_pkg::ADDR_W-1:0]    cfg_paddr,
  input  wire [bale_pkg::DATA_W-1:0]    cfg_pwdata,
  output int                            fail_count,
  output int                            pending,
  output logic [bale_pkg::CNT_W-1:0]    list_len,
  output logic [bale_pkg::CNT_W-1:0]    cap_limit
);
  import bale_pkg::*;

  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [ENTRY_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]       entry_count;
    logic                   is_full;
    logic                   is_empty;
  } list_result_t;

  logic [ENTRY_WIDTH-1:0] shadow_entries [DEPTH];
  int                     held;
  logic [CAP_W-1:0]       capacity_reg;
  list_result_t           awaited_results [$];

  function automatic int bounded_capacity(input logic [CAP_W-1:0] c);
    int r;
    r = int'(c);
    if (r == 0) r = 1;
    if (r > DEPTH) r = DEPTH;
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] place_entry(input int idx,
                                                    input logic [ENTRY_WIDTH-1:0] value);
    int cap;
    cap = bounded_capacity(capacity_reg);
    // index check comes before the full check
    if (idx > cap - 1 || idx > held) return STAT_INVALID;
    if (held >= cap) return STAT_FULL;
    for (int i = held; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[idx] = value;
    held = held + 1;
    return STAT_OK;
  endfunction

  function automatic logic [STAT_W-1:0] drop_entry(input int idx);
    if (idx >= held) return STAT_INVALID;
    for (int i = idx; i + 1 < held; i++) shadow_entries[i] = shadow_entries[i+1];
    held = held - 1;
    return STAT_OK;
  endfunction

  function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [POS_W-1:0] position,
                                                 input logic [ENTRY_WIDTH-1:0] data);
    list_result_t r;
    int pos;
    pos = int'(position);
    r = '0;
    case (mode)
      MODE_INSERT_AT: r.status = place_entry(pos, data);
      MODE_APPEND: begin
        if (held >= bounded_capacity(capacity_reg)) r.status = STAT_FULL;
        else r.status = place_entry(held, data);
      end
      MODE_REMOVE_AT: r.status = drop_entry(pos);
      MODE_REMOVE_LAST: begin
        if (held == 0) r.status = STAT_EMPTY;
        else r.status = drop_entry(held - 1);
      end
      MODE_READ_AT: begin
        if (pos >= held) begin
          r.status = STAT_INVALID;
        end else begin
          r.status    = STAT_OK;
          r.read_data = shadow_entries[pos];
        end
      end
      MODE_CLEAR: begin
        held     = 0;
        r.status = STAT_OK;
      end
      default: r.status = STAT_INVALID;
    endcase
    r.entry_count = CNT_W'(held);
    r.is_full     = (held >= bounded_capacity(capacity_reg));
    r.is_empty    = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    list_result_t seen;
    list_result_t want;
    if (!rst_n) begin
      held         = 0;
      capacity_reg = CAPACITY_RESET;
      fail_count   = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.status      = out_mon.status;
        seen.read_data   = out_mon.read_data;
        seen.entry_count = out_mon.entry_count;
        seen.is_full     = out_mon.is_full;
        seen.is_empty    = out_mon.is_empty;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(seen), 64'(0));
        end else begin
          want = awaited_results.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", 64'(seen.status), 64'(want.status));
          if (seen.read_data !== want.read_data)
            report_mismatch("read_data", 64'(seen.read_data), 64'(want.read_data));
          if (seen.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(seen.entry_count), 64'(want.entry_count));
          if (seen.is_full !== want.is_full)
            report_mismatch("is_full", 64'(seen.is_full), 64'(want.is_full));
          if (seen.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(seen.is_empty), 64'(want.is_empty));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(apply_request(in_mon.mode, in_mon.position,
                                                in_mon.entry_data));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == CAPACITY_ADDR)
        capacity_reg = cfg_pwdata[CAP_W-1:0];
    end
    pending   = awaited_results.size();
    list_len  = CNT_W'(held);
    cap_limit = CNT_W'(bounded_capacity(capacity_reg));
  end

endmodule

// File: verif/bounded_array_list_engine_test.sv
// testbench top: clock, reset, request and configuration stimulus, result pacing, verdict
`timescale 1ns / 100ps
module bounded_array_list_engine_test;
  import bale_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_GAP   = 72;
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam logic [ENTRY_WIDTH-1:0] ALL_ONES = '1;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  int fail_count;
  int pending;
  logic [CNT_W-1:0] list_len;
  logic [CNT_W-1:0] cap_limit;

  bit quiet;
  bit hold_request;
  int cycle_count;

  bale_in_if  in_ch ();
  bale_out_if out_ch ();

  bounded_array_list_engine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bounded_array_list_engine_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .list_len    (list_len),
    .cap_limit   (cap_limit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result side pacing, with an occasional long hold-off so the input backs up
  initial begin : result_pacing
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one request transfer, with a random idle burst in front of it
  task automatic offer_request(input logic [MODE_W-1:0] mode,
                               input logic [POS_W-1:0] position,
                               input logic [ENTRY_WIDTH-1:0] data);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.position   <= position;
    in_ch.entry_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CAPACITY_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // drain all outstanding results before touching the capacity register
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  function automatic logic [ENTRY_WIDTH-1:0] pick_entry();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return ALL_ONES;
    return $urandom;
  endfunction

  // mostly in-range positions so the list actually fills and drains
  task automatic random_request(input bit growing);
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    int roll;
    int len;
    int bound;
    len  = int'(list_len);
    roll = $urandom_range(0, 99);
    if (growing) begin
      if (roll < 40) mode = MODE_INSERT_AT;
      else if (roll < 65) mode = MODE_APPEND;
      else if (roll < 80) mode = MODE_READ_AT;
      else if (roll < 89) mode = MODE_REMOVE_AT;
      else if (roll < 95) mode = MODE_REMOVE_LAST;
      else if (roll < 96) mode = MODE_CLEAR;
      else if (roll < 98) mode = MODE_UNUSED_LO;
      else mode = MODE_UNUSED_HI;
    end else begin
      if (roll < 10) mode = MODE_INSERT_AT;
      else if (roll < 18) mode = MODE_APPEND;
      else if (roll < 35) mode = MODE_READ_AT;
      else if (roll < 68) mode = MODE_REMOVE_AT;
      else if (roll < 94) mode = MODE_REMOVE_LAST;
      else if (roll < 96) mode = MODE_CLEAR;
      else if (roll < 98) mode = MODE_UNUSED_LO;
      else mode = MODE_UNUSED_HI;
    end
    if (mode == MODE_INSERT_AT) bound = (len > DEPTH - 1) ? DEPTH - 1 : len;
    else bound = (len > 0) ? len - 1 : 0;
    if ($urandom_range(0, 99) < 85) position = POS_W'($urandom_range(0, bound));
    else position = POS_W'($urandom_range(0, DEPTH - 1));
    offer_request(mode, position, pick_entry());
  endtask

  initial begin : stimulus
    int plan_caps [10];
    int plan_items [10];
    bit growing;
    plan_caps  = '{64, 1, 0, 127, 65, 8, 33, -1, -1, 64};
    plan_items = '{130, 60, 60, 130, 90, 80, 90, 70, 70, 100};
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_INSERT_AT;
    in_ch.position   = '0;
    in_ch.entry_data = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases
    offer_request(MODE_REMOVE_AT, 6'd0, 32'h0);
    offer_request(MODE_REMOVE_LAST, 6'd0, 32'h0);
    offer_request(MODE_READ_AT, 6'd0, 32'h0);
    offer_request(MODE_INSERT_AT, 6'd1, 32'h1234_5678);
    // build a short list, inserting at the front and in the middle
    offer_request(MODE_INSERT_AT, 6'd0, ALL_ONES);
    offer_request(MODE_INSERT_AT, 6'd0, 32'h0);
    offer_request(MODE_APPEND, 6'd63, 32'hA5A5_5A5A);
    offer_request(MODE_INSERT_AT, 6'd1, 32'h5A5A_A5A5);
    offer_request(MODE_READ_AT, 6'd0, 32'h0);
    offer_request(MODE_READ_AT, 6'd1, 32'h0);
    offer_request(MODE_READ_AT, 6'd2, 32'h0);
    offer_request(MODE_READ_AT, 6'd3, 32'h0);
    offer_request(MODE_READ_AT, 6'd63, 32'h0);
    offer_request(MODE_UNUSED_LO, 6'd0, ALL_ONES);
    offer_request(MODE_UNUSED_HI, 6'd63, ALL_ONES);
    offer_request(MODE_REMOVE_AT, 6'd1, 32'h0);
    offer_request(MODE_REMOVE_LAST, 6'd0, 32'h0);
    offer_request(MODE_CLEAR, 6'd0, 32'h0);
    offer_request(MODE_READ_AT, 6'd0, 32'h0);
    // tiny capacity: full list, and a bad index reported before full
    wait_drained();
    write_capacity(32'd2);
    offer_request(MODE_APPEND, 6'd0, 32'hDEAD_BEEF);
    offer_request(MODE_APPEND, 6'd0, 32'hCAFE_F00D);
    offer_request(MODE_APPEND, 6'd0, 32'h1111_1111);
    offer_request(MODE_INSERT_AT, 6'd2, 32'h2222_2222);
    offer_request(MODE_INSERT_AT, 6'd0, 32'h3333_3333);

    // random phases, counts carry over so a lowered capacity sees an overfull list
    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      if (plan_caps[ph] < 0) write_capacity(DATA_W'($urandom_range(0, 127)));
      else write_capacity(DATA_W'(plan_caps[ph]));
      if (ph == 9) quiet = 1'b1;
      if (ph == 2 || ph == 5) hold_request = 1'b1;
      growing = 1'b1;
      for (int n = 0; n < plan_items[ph]; n++) begin
        if (list_len >= cap_limit) growing = 1'b0;
        else if (list_len == 0) growing = 1'b1;
        random_request(growing);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bale_pkg.sv
hw/rtl/bale_chan_if.sv
hw/rtl/bale_mem.sv
hw/rtl/bale_ctrl.sv
hw/rtl/bounded_array_list_engine.sv
verif/bounded_array_list_engine_checker.sv
verif/bounded_array_list_engine_test.sv
